@@ hw/rtl/wla_pkg.sv @@
`timescale 1ns / 1ps

package wla_pkg;

	localparam int NUM_ENTRIES = 64;

	localparam int IDX_W  = 6;
	localparam int TKT_W  = 16;
	localparam int MASK_W = 64;
	localparam int TOT_W  = 22;
	localparam int SEED_W = 31;
	localparam int PROD_W = 46;

	localparam int ROWS  = (NUM_ENTRIES + 1) / 2;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam logic [MASK_W-1:0] ENT_MASK = (NUM_ENTRIES == MASK_W) ? {MASK_W{1'b1}} :
		((MASK_W'(1) << NUM_ENTRIES) - MASK_W'(1));

	localparam logic [TKT_W-1:0]  INIT_TICKETS = 16'd10;
	localparam logic [SEED_W-1:0] SEED_INIT    = 31'd1;
	localparam logic [SEED_W-1:0] LCG_MODM1    = 31'h7ffffffe;
	localparam logic [SEED_W-1:0] LCG_MOD      = 31'h7fffffff;
	localparam logic [14:0]       LCG_A        = 15'd16807;

	localparam int MOD_STEPS = 16;
	localparam int MOD_CNT_W = 4;

	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_PICK  = 1'b1;

	typedef enum logic [1:0] {
		STS_STORED = 2'd0,
		STS_GRANT  = 2'd1,
		STS_EMPTY  = 2'd2
	} sts_t;

endpackage

@@ hw/rtl/wla_mod.sv @@
`timescale 1ns / 1ps

module wla_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wla_pkg::SEED_W-1:0]  dividend,
	input  logic [wla_pkg::TOT_W-1:0]   divisor,
	output logic                        done,
	output logic [wla_pkg::TOT_W-1:0]   remainder
);
	import wla_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [SEED_W:0]      dvd_q;
	logic [TOT_W-1:0]     rem_q;
	logic [TOT_W-1:0]     dsr_q;
	logic [TOT_W:0]       r1;
	logic [TOT_W:0]       r2;
	logic [TOT_W-1:0]     q1;
	logic [TOT_W-1:0]     q2;

	// two restoring steps per cycle
	always_comb begin
		r1 = {rem_q, dvd_q[SEED_W]};
		q1 = (r1 >= {1'b0, dsr_q}) ? TOT_W'(r1 - {1'b0, dsr_q}) : r1[TOT_W-1:0];
		r2 = {q1, dvd_q[SEED_W-1]};
		q2 = (r2 >= {1'b0, dsr_q}) ? TOT_W'(r2 - {1'b0, dsr_q}) : r2[TOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= {1'b0, dividend};
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= q2;
				dvd_q <= dvd_q << 2;
				cnt_q <= cnt_q + MOD_CNT_W'(1);
				if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ hw/rtl/weighted_lottery_arbiter.sv @@
`timescale 1ns / 1ps

// Weighted lottery arbiter.
// Input channel (in_valid/in_stall) takes one word per item: action 0 stores
// ticket_count for entry_index, action 1 picks a winner among the entries set
// in runnable_mask. Output channel (out_valid/out_stall) returns one word per
// item: status, winner, draw and total_tickets.
// Items are handled one at a time; in_stall is high while an item is in work,
// so the next word is taken the cycle after the result word is registered.
// Tickets live in two banks (even and odd entries) of 32 rows, read one row
// a cycle, so the row sweep sets the pick time.
// Store: the item goes straight to ST_EMIT, which registers the result word
// once the output register is free. Pick: one sweep to sum, a check of the
// total, a 2-bit-per-cycle remainder unit, then a second sweep that stops
// at the winning row, then the word is presented; a pick with no runnable
// tickets skips the remainder unit and the second sweep.
// Reset: every entry reads 10 tickets, generator seed is 1, both channels idle.
// A stalled result word holds on the outputs; the next item's result waits
// in the block until the output register is free.
module weighted_lottery_arbiter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [wla_pkg::IDX_W-1:0]   entry_index,
	input  logic [wla_pkg::TKT_W-1:0]   ticket_count,
	input  logic [wla_pkg::MASK_W-1:0]  runnable_mask,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [wla_pkg::IDX_W-1:0]   winner,
	output logic [wla_pkg::TOT_W-1:0]   draw,
	output logic [wla_pkg::TOT_W-1:0]   total_tickets
);
	import wla_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_GEN,
		ST_MOD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [TKT_W-1:0] mem_even [ROWS];
	logic [TKT_W-1:0] mem_odd  [ROWS];
	logic [ROWS-1:0]  vld_even_q;
	logic [ROWS-1:0]  vld_odd_q;

	logic [TKT_W-1:0] even_s1;
	logic [TKT_W-1:0] odd_s1;
	logic [ROW_W-1:0] row_s1;
	logic             dv_s1;

	logic [ROW_W-1:0]  row_q;
	logic              iss_q;
	logic [MASK_W-1:0] mask_q;
	logic [MASK_W-1:0] sh_q;
	logic [TOT_W-1:0]  acc_q;
	logic [TOT_W-1:0]  tot_q;
	logic [TOT_W-1:0]  draw_q;
	logic [IDX_W-1:0]  win_q;
	sts_t              sts_q;

	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] x_q;
	logic [PROD_W-1:0] prod_q;
	logic [SEED_W-1:0] rnd_q;

	logic              out_valid_q;
	sts_t              out_sts_q;
	logic [IDX_W-1:0]  out_win_q;
	logic [TOT_W-1:0]  out_draw_q;
	logic [TOT_W-1:0]  out_tot_q;

	logic              in_acc;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_row;
	logic [TKT_W-1:0]  te;
	logic [TKT_W-1:0]  to;
	logic [TOT_W-1:0]  a0;
	logic [TOT_W-1:0]  a1;
	logic              hit0;
	logic              hit1;
	logic [IDX_W-1:0]  ent_even;
	logic [IDX_W-1:0]  ent_odd;
	logic [SEED_W-1:0] x_next;
	logic [SEED_W:0]   fsum;
	logic [SEED_W-1:0] rnd_next;
	logic              mod_start;
	logic              mod_done;
	logic [TOT_W-1:0]  mod_rem;
	logic              out_free;

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign wr_en    = in_acc && (action == ACT_STORE) && (32'(entry_index) < NUM_ENTRIES);
	assign wr_row   = ROW_W'(entry_index >> 1);
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (entry_index[0]) begin
				mem_odd[wr_row] <= ticket_count;
			end else begin
				mem_even[wr_row] <= ticket_count;
			end
		end
		even_s1 <= mem_even[row_q];
		odd_s1  <= mem_odd[row_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_even_q <= '0;
			vld_odd_q  <= '0;
		end else if (wr_en) begin
			if (entry_index[0]) begin
				vld_odd_q[wr_row] <= 1'b1;
			end else begin
				vld_even_q[wr_row] <= 1'b1;
			end
		end
	end

	always_comb begin
		te   = vld_even_q[row_s1] ? even_s1 : INIT_TICKETS;
		to   = vld_odd_q[row_s1] ? odd_s1 : INIT_TICKETS;
		a0   = acc_q + (sh_q[0] ? TOT_W'(te) : '0);
		a1   = a0 + (sh_q[1] ? TOT_W'(to) : '0);
		hit0 = sh_q[0] && (a0 >= draw_q);
		hit1 = sh_q[1] && (a1 >= draw_q);
		ent_even = IDX_W'({row_s1, 1'b0});
		ent_odd  = IDX_W'({row_s1, 1'b1});
	end

	// fold 16807*x modulo 2^31-1, then step down by one
	always_comb begin
		x_next   = ((seed_q >= LCG_MODM1) ? SEED_W'(seed_q - LCG_MODM1) : seed_q)
			+ SEED_W'(1);
		fsum     = (SEED_W + 1)'(prod_q[SEED_W-1:0]) + (SEED_W + 1)'(prod_q[PROD_W-1:SEED_W]);
		rnd_next = (fsum >= {1'b0, LCG_MOD}) ? SEED_W'(fsum - {1'b0, LCG_MOD} - 1'b1)
			: SEED_W'(fsum - 1'b1);
	end

	assign mod_start = (state_q == ST_GEN) && (tot_q != '0);

	wla_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (rnd_q),
		.divisor   (tot_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			iss_q       <= 1'b0;
			row_s1      <= '0;
			dv_s1       <= 1'b0;
			mask_q      <= '0;
			sh_q        <= '0;
			acc_q       <= '0;
			tot_q       <= '0;
			draw_q      <= '0;
			win_q       <= '0;
			sts_q       <= STS_STORED;
			seed_q      <= SEED_INIT;
			x_q         <= '0;
			prod_q      <= '0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
			out_sts_q   <= STS_STORED;
			out_win_q   <= '0;
			out_draw_q  <= '0;
			out_tot_q   <= '0;
		end else begin
			dv_s1  <= iss_q;
			row_s1 <= row_q;
			if (iss_q) begin
				row_q <= row_q + ROW_W'(1);
				if (row_q == ROW_W'(ROWS - 1)) begin
					iss_q <= 1'b0;
				end
			end
			prod_q <= PROD_W'(x_q) * PROD_W'(LCG_A);
			rnd_q  <= rnd_next;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (action == ACT_PICK) begin
							mask_q  <= runnable_mask & ENT_MASK;
							sh_q    <= runnable_mask & ENT_MASK;
							x_q     <= x_next;
							acc_q   <= '0;
							row_q   <= '0;
							iss_q   <= 1'b1;
							state_q <= ST_SUM;
						end else begin
							sts_q   <= STS_STORED;
							win_q   <= '0;
							draw_q  <= '0;
							tot_q   <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SUM: begin
					if (dv_s1) begin
						acc_q <= a1;
						sh_q  <= sh_q >> 2;
						if (row_s1 == ROW_W'(ROWS - 1)) begin
							tot_q   <= a1;
							state_q <= ST_GEN;
						end
					end
				end
				ST_GEN: begin
					if (tot_q == '0) begin
						sts_q   <= STS_EMPTY;
						win_q   <= '0;
						draw_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						seed_q  <= rnd_q;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						draw_q  <= mod_rem + TOT_W'(1);
						sh_q    <= mask_q;
						acc_q   <= '0;
						row_q   <= '0;
						iss_q   <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dv_s1) begin
						acc_q <= a1;
						sh_q  <= sh_q >> 2;
						priority if (hit0) begin
							win_q   <= ent_even;
							sts_q   <= STS_GRANT;
							iss_q   <= 1'b0;
							state_q <= ST_EMIT;
						end else if (hit1) begin
							win_q   <= ent_odd;
							sts_q   <= STS_GRANT;
							iss_q   <= 1'b0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_sts_q   <= sts_q;
						out_win_q   <= win_q;
						out_draw_q  <= draw_q;
						out_tot_q   <= tot_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_sts_q;
	assign winner        = out_win_q;
	assign draw          = out_draw_q;
	assign total_tickets = out_tot_q;

endmodule

@@ tb/weighted_lottery_arbiter_tb.sv @@
`timescale 1ns / 1ps

module weighted_lottery_arbiter_tb;
	import wla_pkg::*;

	localparam longint PM_MODM1 = 64'h7ffffffe;
	localparam longint PM_MOD   = 64'h7fffffff;
	localparam longint PM_Q     = 127773;
	localparam longint PM_A     = 16807;
	localparam longint PM_R     = 2836;
	localparam int RANDOM_WORDS = 1330;

	typedef struct packed {
		sts_t               status;
		logic [IDX_W-1:0]   winner;
		logic [TOT_W-1:0]   draw;
		logic [TOT_W-1:0]   total;
	} lottery_result_t;

	typedef struct packed {
		logic               act;
		logic [IDX_W-1:0]   idx;
		logic [TKT_W-1:0]   cnt;
		logic [MASK_W-1:0]  mask;
		bit                 typed;
		lottery_result_t    res;
	} plan_row_t;

	localparam lottery_result_t STORED_WORD = '{STS_STORED, '0, '0, '0};
	localparam lottery_result_t EMPTY_WORD  = '{STS_EMPTY, '0, '0, '0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               action = ACT_STORE;
	logic [IDX_W-1:0]   entry_index = '0;
	logic [TKT_W-1:0]   ticket_count = '0;
	logic [MASK_W-1:0]  runnable_mask = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [IDX_W-1:0]   winner;
	logic [TOT_W-1:0]   draw;
	logic [TOT_W-1:0]   total_tickets;

	logic [TKT_W-1:0]   ticket_shadow [NUM_ENTRIES];
	logic [SEED_W-1:0]  prng_state;
	lottery_result_t    pending_results [$];
	plan_row_t          directed [$];

	int fail_count = 0;
	int store_count = 0;
	int grant_count = 0;
	int empty_count = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_left = 0;
	logic [TOT_W-1:0] peak_total = '0;

	always #2 clk = ~clk;

	weighted_lottery_arbiter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.entry_index   (entry_index),
		.ticket_count  (ticket_count),
		.runnable_mask (runnable_mask),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.winner        (winner),
		.draw          (draw),
		.total_tickets (total_tickets)
	);

	function automatic logic [SEED_W-1:0] park_miller_next();
		longint x;
		longint hi;
		longint lo;
		longint t;
		x = (longint'(prng_state) % PM_MODM1) + 1;
		hi = x / PM_Q;
		lo = x % PM_Q;
		t = PM_A * lo - PM_R * hi;
		if (t < 0) begin
			t += PM_MOD;
		end
		t -= 1;
		if (t < 0) begin
			t = 0;
		end
		prng_state = t[SEED_W-1:0];
		return prng_state;
	endfunction

	function automatic lottery_result_t lottery_outcome(input logic act,
			input logic [IDX_W-1:0] idx, input logic [TKT_W-1:0] cnt,
			input logic [MASK_W-1:0] mask);
		lottery_result_t res;
		int unsigned total;
		int unsigned acc;
		int unsigned ticket;
		bit found;
		res = STORED_WORD;
		if (act == ACT_STORE) begin
			ticket_shadow[idx] = cnt;
			return res;
		end
		total = 0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (mask[i]) begin
				total += ticket_shadow[i];
			end
		end
		res.total = total[TOT_W-1:0];
		if (total == 0) begin
			res.status = STS_EMPTY;
			return res;
		end
		res.status = STS_GRANT;
		ticket = (park_miller_next() % total) + 1;
		res.draw = ticket[TOT_W-1:0];
		acc = 0;
		found = 1'b0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (mask[i] && !found) begin
				if (ticket > acc && ticket <= acc + ticket_shadow[i]) begin
					res.winner = IDX_W'(i);
					found = 1'b1;
				end
				acc += ticket_shadow[i];
			end
		end
		return res;
	endfunction

	function automatic void add_directed(input logic act, input logic [IDX_W-1:0] idx,
			input logic [TKT_W-1:0] cnt, input logic [MASK_W-1:0] mask,
			input bit typed, input lottery_result_t res);
		directed.push_back('{act, idx, cnt, mask, typed, res});
	endfunction

	task automatic send_word(input logic act, input logic [IDX_W-1:0] idx,
			input logic [TKT_W-1:0] cnt, input logic [MASK_W-1:0] mask,
			input bit typed, input lottery_result_t typed_res);
		lottery_result_t res;
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) :
				$urandom_range(1, 8);
		end
		action <= act;
		entry_index <= idx;
		ticket_count <= cnt;
		runnable_mask <= mask;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		res = lottery_outcome(act, idx, cnt, mask);
		case (res.status)
			STS_STORED: store_count++;
			STS_GRANT:  grant_count++;
			default:    empty_count++;
		endcase
		if (res.total > peak_total) begin
			peak_total = res.total;
		end
		pending_results.push_back(typed ? typed_res : res);
		burst_left--;
	endtask

	// hold the output word on a random stall pattern; the stall percentage (0, 30, 60 or 90) is redrawn when its run ends
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_pct = 30 * $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		lottery_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t ns: result word with nothing expected: status %0d winner %0d draw %0d total %0d",
					$time, status, winner, draw, total_tickets);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || winner !== want.winner ||
						draw !== want.draw || total_tickets !== want.total) begin
					fail_count++;
					$display("%0t ns: expected status %0d winner %0d draw %0d total %0d",
						$time, want.status, want.winner, want.draw, want.total);
					$display("%0t ns: actual   status %0d winner %0d draw %0d total %0d",
						$time, status, winner, draw, total_tickets);
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("weighted_lottery_arbiter verification failed");
		$finish;
	end

	initial begin
		int sent;
		int flood_count;
		int pick_kind;
		logic [MASK_W-1:0] pick_mask;
		logic [TKT_W-1:0] store_cnt;
		sent = 0;
		flood_count = 0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			ticket_shadow[i] = INIT_TICKETS;
		end
		prng_state = SEED_INIT;

		add_directed(ACT_PICK, 6'd0, 16'd0, '1, 1, '{STS_GRANT, 6'd33, 22'd334, 22'd640});
		add_directed(ACT_PICK, 6'd0, 16'd0, '0, 1, EMPTY_WORD);
		add_directed(ACT_STORE, 6'd0, 16'd0, '0, 1, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, 64'h1, 1, EMPTY_WORD);
		add_directed(ACT_STORE, 6'd5, 16'd1, '0, 1, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, 64'h20, 1, '{STS_GRANT, 6'd5, 22'd1, 22'd1});
		add_directed(ACT_PICK, 6'd0, 16'd0, 64'h21, 1, '{STS_GRANT, 6'd5, 22'd1, 22'd1});
		add_directed(ACT_STORE, 6'd63, 16'hffff, '0, 1, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, 64'h8000_0000_0000_0000, 0, STORED_WORD);
		add_directed(ACT_STORE, 6'd62, 16'hffff, '1, 1, STORED_WORD);
		add_directed(ACT_PICK, 6'd63, 16'hffff, 64'hc000_0000_0000_0000, 0, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, '1, 0, STORED_WORD);
		add_directed(ACT_STORE, 6'd1, 16'haaaa, '0, 1, STORED_WORD);
		add_directed(ACT_STORE, 6'd2, 16'h5555, '0, 1, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, 64'haaaa_aaaa_aaaa_aaaa, 0, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, 64'h5555_5555_5555_5555, 0, STORED_WORD);
		add_directed(ACT_STORE, 6'd5, 16'd0, '0, 1, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, 64'h21, 1, EMPTY_WORD);
		add_directed(ACT_STORE, 6'd0, 16'd10, '0, 1, STORED_WORD);
		add_directed(ACT_PICK, 6'd0, 16'd0, '1, 0, STORED_WORD);

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed[j]) begin
			send_word(directed[j].act, directed[j].idx, directed[j].cnt, directed[j].mask,
				directed[j].typed, directed[j].res);
		end

		while (sent < RANDOM_WORDS) begin
			pick_kind = $urandom_range(0, 99);
			if (pick_kind < 2 && sent > 300 && flood_count < 2) begin
				// first flood saturates every entry, second one empties the table
				store_cnt = (flood_count == 0) ? '1 : '0;
				for (int e = 0; e < NUM_ENTRIES; e++) begin
					send_word(ACT_STORE, IDX_W'(e), store_cnt, '0, 0, STORED_WORD);
				end
				send_word(ACT_PICK, '0, '0, '1, 0, STORED_WORD);
				sent += NUM_ENTRIES + 1;
				flood_count++;
			end else if (pick_kind < 37) begin
				pick_kind = $urandom_range(0, 5);
				if (pick_kind == 0) begin
					store_cnt = '0;
				end else if (pick_kind == 1) begin
					store_cnt = '1;
				end else if (pick_kind == 2) begin
					store_cnt = TKT_W'($urandom_range(1, 15));
				end else begin
					store_cnt = TKT_W'($urandom_range(0, 65535));
				end
				send_word(ACT_STORE, IDX_W'($urandom_range(0, NUM_ENTRIES - 1)), store_cnt,
					{$urandom, $urandom}, 0, STORED_WORD);
				sent++;
			end else begin
				pick_kind = $urandom_range(0, 9);
				if (pick_kind == 0) begin
					pick_mask = '0;
				end else if (pick_kind == 1) begin
					pick_mask = '1;
				end else if (pick_kind == 2) begin
					pick_mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
				end else if (pick_kind < 5) begin
					pick_mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
				end else begin
					pick_mask = {$urandom, $urandom};
				end
				send_word(ACT_PICK, IDX_W'($urandom), TKT_W'($urandom), pick_mask, 0, STORED_WORD);
				sent++;
			end
		end

		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d ticket stores, %0d granted picks, %0d picks with no runnable tickets",
			store_count, grant_count, empty_count);
		$display("largest ticket total seen in a pick: %0d", peak_total);
		if (fail_count == 0) begin
			$display("weighted_lottery_arbiter verification clean");
		end else begin
			$display("weighted_lottery_arbiter verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/wla_pkg.sv
hw/rtl/wla_mod.sv
hw/rtl/weighted_lottery_arbiter.sv
tb/weighted_lottery_arbiter_tb.sv
